>>> hw/rtl/bfow_pkg.sv
// ----------------------------------------------------------------------------
// bfow_pkg
// Shared types and codes of the byte ring FIFO with overwrite and watermarks.
// ----------------------------------------------------------------------------
`default_nettype none

package bfow_pkg;

  // command codes
  localparam logic [1:0] CMD_PUSH  = 2'd0;
  localparam logic [1:0] CMD_POP   = 2'd1;
  localparam logic [1:0] CMD_FLUSH = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_HIGH_MARK   = 2'd0;
  localparam logic [1:0] REG_LOW_MARK    = 2'd1;
  localparam logic [1:0] REG_OVERWRITE   = 2'd2;
  localparam logic [1:0] REG_BURST_MODE  = 2'd3;

  localparam logic [8:0] HIGH_MARK_RST = 9'd256;
  localparam logic [8:0] LOW_MARK_RST  = 9'd0;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] push_byte;
    logic [8:0] burst_length;
    logic       burst_end;
  } in_word_t;

  typedef struct packed {
    logic       accepted;
    logic [7:0] pop_byte;
    logic [8:0] level;
    logic       is_empty;
    logic       is_full;
    logic       above_high;
    logic       below_low;
  } out_word_t;

  typedef struct packed {
    logic [8:0] high_mark;
    logic [8:0] low_mark;
    logic       overwrite_on;
    logic       burst_mode;
  } cfg_t;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_t;

endpackage

`default_nettype wire

>>> hw/rtl/byte_fifo_overwrite_watermark.sv
// ----------------------------------------------------------------------------
// byte_fifo_overwrite_watermark
// Byte ring FIFO driven by push, pop and flush command words.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall/in_data carry one command word; out_valid/out_stall/
//   out_data return exactly one result word per command. A word moves on a
//   clock edge with valid high and stall low.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write the high mark, low mark,
//   overwrite enable and burst mode; cfg_ready is always high. Write them
//   only while no command is in flight.
//   Push, flush, unused and empty-pop commands: the result is loaded into
//   the output register on the edge that takes the command, and the next
//   command may follow at once. A successful pop waits in ST_READ for the
//   registered read of the storage RAM, whose data goes into the result
//   from there; no command is taken in ST_READ.
//   The output register decouples the sides: a command is still taken while
//   a result waits, as long as that result leaves on the same edge. While
//   out_stall holds a result, in_stall stays high.
//   Synchronous reset empties the FIFO, closes any burst and restores the
//   register defaults. The storage RAM is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_fifo_overwrite_watermark
  import bfow_pkg::*;
#(
  parameter int DEPTH = 256
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_word_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_word_t      out_data,
  input  wire logic      cfg_valid,
  output logic           cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [8:0] cfg_data
);

  localparam int AW = $clog2(DEPTH);

  state_t    state_r, state_nxt;
  cfg_t      cfg_r, cfg_nxt;
  out_word_t out_data_r, out_data_nxt;
  out_word_t pend_r, pend_nxt;
  logic      out_valid_r, out_valid_nxt;

  logic          in_fire;
  logic          load_imm;
  logic          load_rd;
  out_word_t     res;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;

  bfow_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (in_fire),
    .item    (in_data),
    .cfg     (cfg_r),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .res     (res)
  );

  bfow_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_fire   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && rd_en) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall = 1'b1;
    load_imm = 1'b0;
    load_rd  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = out_valid_r && out_stall;
        load_imm = in_fire && !rd_en;
      end
      ST_READ: begin
        load_rd = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    pend_nxt = in_fire ? res : pend_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (load_imm) begin
      out_data_nxt  = res;
      out_valid_nxt = 1'b1;
    end else if (load_rd) begin
      out_data_nxt          = pend_r;
      out_data_nxt.pop_byte = rd_data;
      out_valid_nxt         = 1'b1;
    end
  end

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_HIGH_MARK:  cfg_nxt.high_mark    = cfg_data;
        REG_LOW_MARK:   cfg_nxt.low_mark     = cfg_data;
        REG_OVERWRITE:  cfg_nxt.overwrite_on = cfg_data[0];
        REG_BURST_MODE: cfg_nxt.burst_mode   = cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r            <= ST_IDLE;
      out_valid_r        <= 1'b0;
      cfg_r.high_mark    <= HIGH_MARK_RST;
      cfg_r.low_mark     <= LOW_MARK_RST;
      cfg_r.overwrite_on <= 1'b0;
      cfg_r.burst_mode   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cfg_r       <= cfg_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    pend_r     <= pend_nxt;
  end

endmodule

`default_nettype wire

>>> hw/rtl/bfow_ram.sv
// ----------------------------------------------------------------------------
// bfow_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bfow_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/bfow_ctrl.sv
// ----------------------------------------------------------------------------
// bfow_ctrl
// Index, level and burst bookkeeping; drives the storage RAM ports and builds
// the status part of each result word.
// ----------------------------------------------------------------------------
`default_nettype none

module bfow_ctrl
  import bfow_pkg::*;
#(
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     fire,
  input  wire in_word_t                 item,
  input  wire cfg_t                     cfg,
  output logic                          wr_en,
  output logic      [$clog2(DEPTH)-1:0] wr_addr,
  output logic      [7:0]               wr_data,
  output logic                          rd_en,
  output logic      [$clog2(DEPTH)-1:0] rd_addr,
  output out_word_t                     res
);

  localparam int AW = $clog2(DEPTH);
  localparam int LW = $clog2(DEPTH + 1);
  localparam int NW = ((LW > 9) ? LW : 9) + 1;
  localparam logic [NW-1:0] DEPTH_N = NW'(DEPTH);
  localparam logic [LW-1:0] DEPTH_L = LW'(DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

  logic [AW-1:0] wi_r, wi_nxt;
  logic [AW-1:0] ri_r, ri_nxt;
  logic [LW-1:0] lvl_r, lvl_nxt;
  logic          bopen_r, bopen_nxt;
  logic          bref_r, bref_nxt;

  logic [NW-1:0] blen_ext;
  logic [NW-1:0] need;
  logic [NW-1:0] sum;
  logic [NW-1:0] drop;
  logic [NW-1:0] ri_sum;
  logic          over;
  logic [AW-1:0] ri_drop;
  logic [LW-1:0] lvl_drop;

  logic [AW-1:0] ri_a;
  logic [LW-1:0] lvl_a;
  logic          do_store;
  logic          ok;

  function automatic logic [AW-1:0] adv(input logic [AW-1:0] idx);
    return (idx == LAST_IDX) ? '0 : AW'(idx + 1'b1);
  endfunction

  // burst fit check, worked out once on the first byte of a burst
  assign blen_ext = NW'(item.burst_length);
  assign need     = (blen_ext == '0) ? NW'(1) :
                    ((blen_ext > DEPTH_N) ? DEPTH_N : blen_ext);
  assign sum      = NW'(lvl_r) + need;
  assign over     = sum > DEPTH_N;
  assign drop     = sum - DEPTH_N;
  assign ri_sum   = NW'(ri_r) + drop;
  assign ri_drop  = (ri_sum >= DEPTH_N) ? AW'(ri_sum - DEPTH_N) : AW'(ri_sum);
  assign lvl_drop = LW'(DEPTH_N - need);

  always_comb begin
    wi_nxt    = wi_r;
    bopen_nxt = bopen_r;
    bref_nxt  = bref_r;
    ri_a      = ri_r;
    lvl_a     = lvl_r;
    do_store  = 1'b0;
    ok        = 1'b0;
    wr_en     = 1'b0;
    rd_en     = 1'b0;
    if (fire) begin
      unique case (item.command)
        CMD_PUSH: begin
          if (!cfg.burst_mode) begin
            bopen_nxt = 1'b0;
            bref_nxt  = 1'b0;
            do_store  = 1'b1;
          end else begin
            if (!bopen_r) begin
              bref_nxt = 1'b0;
              if (over) begin
                if (!cfg.overwrite_on) begin
                  bref_nxt = 1'b1;
                end else begin
                  ri_a  = ri_drop;
                  lvl_a = lvl_drop;
                end
              end
              bopen_nxt = 1'b1;
            end
            do_store = !bref_nxt;
            if (item.burst_end) begin
              bopen_nxt = 1'b0;
              bref_nxt  = 1'b0;
            end
          end
        end
        CMD_POP: begin
          if (lvl_r != '0) begin
            rd_en = 1'b1;
            ri_a  = adv(ri_r);
            lvl_a = lvl_r - 1'b1;
            ok    = 1'b1;
          end
        end
        CMD_FLUSH: begin
          wi_nxt    = '0;
          ri_a      = '0;
          lvl_a     = '0;
          bopen_nxt = 1'b0;
          bref_nxt  = 1'b0;
          ok        = 1'b1;
        end
        default: begin
        end
      endcase
    end
    // single-byte store; on a full FIFO drop the oldest byte or refuse
    if (do_store && !((lvl_a == DEPTH_L) && !cfg.overwrite_on)) begin
      if (lvl_a == DEPTH_L) begin
        ri_a  = adv(ri_a);
        lvl_a = lvl_a - 1'b1;
      end
      wr_en  = 1'b1;
      wi_nxt = adv(wi_r);
      lvl_a  = lvl_a + 1'b1;
      ok     = 1'b1;
    end
    ri_nxt  = ri_a;
    lvl_nxt = lvl_a;
  end

  assign wr_addr = wi_r;
  assign wr_data = item.push_byte;
  assign rd_addr = ri_r;

  always_comb begin
    res            = '0;
    res.accepted   = ok;
    res.level      = 9'(lvl_nxt);
    res.is_empty   = (lvl_nxt == '0);
    res.is_full    = (lvl_nxt == DEPTH_L);
    res.above_high = (NW'(lvl_nxt) >= NW'(cfg.high_mark));
    res.below_low  = (NW'(lvl_nxt) <= NW'(cfg.low_mark));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wi_r    <= '0;
      ri_r    <= '0;
      lvl_r   <= '0;
      bopen_r <= 1'b0;
      bref_r  <= 1'b0;
    end else begin
      wi_r    <= wi_nxt;
      ri_r    <= ri_nxt;
      lvl_r   <= lvl_nxt;
      bopen_r <= bopen_nxt;
      bref_r  <= bref_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/bfow_checker.sv
// ----------------------------------------------------------------------------
// bfow_checker
// Port-level checks of the byte ring FIFO, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bfow_checker
  import bfow_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_word_t out_data
);

  // a held result word stays up
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  a_empty_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.is_empty |-> out_data.level == 9'd0)
    else $error("empty flag with nonzero level");

  a_empty_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.is_empty && out_data.is_full))
    else $error("empty and full at once");

  a_refused_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.accepted |-> out_data.pop_byte == 8'd0)
    else $error("refused command carries a byte");

endmodule

bind byte_fifo_overwrite_watermark bfow_checker u_bfow_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
